### sv/ctwc_pkg.sv
package ctwc_pkg;

   localparam int WordWidth  = 256;
   localparam int MantWidth  = 23;
   localparam int CountWidth = 8;
   localparam int ShiftWidth = 5;

   localparam logic [31:0] MANT_MASK           = 32'h007f_ffff;
   localparam logic [31:0] SIGN_BIT            = 32'h0080_0000;
   localparam logic [31:0] DEFAULT_MAX_COMPACT = 32'h1d00_ffff;
   localparam logic [7:0]  EXP_LIMIT           = 8'd34;

   localparam logic       MODE_TO_WORK   = 1'b0;
   localparam logic       MODE_TO_TARGET = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_ZERO     = 2'd1;
   localparam logic [1:0] STATUS_EXP_HIGH = 2'd2;

   typedef struct packed {
      logic        mode;
      logic [31:0] compact_in;
      logic [63:0] value_word3;
      logic [63:0] value_word2;
      logic [63:0] value_word1;
      logic [63:0] value_word0;
   } ctwc_req_type;

   typedef struct packed {
      logic [63:0] result_word3;
      logic [63:0] result_word2;
      logic [63:0] result_word1;
      logic [63:0] result_word0;
      logic [31:0] compact_out;
      logic [1:0]  status;
   } ctwc_rsp_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic step;
      logic post;
      logic pack_step;
      logic out_load;
   } ctwc_cmd_type;

   typedef struct packed {
      logic pack_more;
   } ctwc_sts_type;

endpackage

### sv/ctwc_ctrl.sv
module ctwc_ctrl
   import ctwc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ctwc_cmd_type cmd,
   input  ctwc_sts_type sts
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PREP = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_POST = 3'd3;
   localparam logic [2:0] S_PACK = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd           = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               state_in = S_POST;
            end
         end
         S_POST: begin
            cmd.post = 1'b1;
            state_in = S_PACK;
         end
         S_PACK: begin
            if (sts.pack_more) begin
               cmd.pack_step = 1'b1;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### sv/ctwc_dpath.sv
module ctwc_dpath
   import ctwc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ctwc_req_type req_data,
   input  logic         csr_valid,
   input  logic [31:0]  csr_data,
   output ctwc_rsp_type rsp_data,
   input  ctwc_cmd_type cmd,
   output ctwc_sts_type sts
);

   logic [31:0]           max_ff;
   logic                  mode_ff;
   logic [1:0]            stat_ff, stat_in;
   logic [WordWidth-1:0]  den_ff, nq_ff, rem_ff, res_ff;
   logic [ShiftWidth-1:0] k_ff;
   ctwc_rsp_type          rsp_ff, rsp_in;

   // operand expansion
   logic [7:0]            exp_in;
   logic [MantWidth-1:0]  mant_in;
   logic [7:0]            exp_m3;
   logic [WordWidth-1:0]  target_in, work_in;

   assign exp_in   = req_data.compact_in[31:24];
   assign mant_in  = req_data.compact_in[MantWidth-1:0];
   assign exp_m3   = exp_in - 8'd3;
   assign work_in  = {req_data.value_word3, req_data.value_word2,
                      req_data.value_word1, req_data.value_word0};

   always_comb begin
      if (exp_in <= 8'd3) begin
         target_in = WordWidth'(mant_in >> {2'd3 - exp_in[1:0], 3'b000});
      end else begin
         target_in = WordWidth'(mant_in) << {exp_m3[4:0], 3'b000};
      end
      if (req_data.mode == MODE_TO_WORK) begin
         stat_in = (exp_in > EXP_LIMIT) ? STATUS_EXP_HIGH : STATUS_OK;
      end else begin
         stat_in = (work_in == '0) ? STATUS_ZERO : STATUS_OK;
      end
   end

   // restoring divide step
   logic [WordWidth:0] trial;
   logic               take;

   assign trial = {rem_ff, nq_ff[WordWidth-1]} - {1'b0, den_ff};
   assign take  = !trial[WordWidth];

   // normalizer
   assign sts.pack_more = (nq_ff[WordWidth-1:24] != '0);

   // compact packing
   logic [23:0] mant_top;
   logic [1:0]  nbytes;
   logic [31:0] mant_sh, mant_fix;
   logic [5:0]  size_raw, size_fix;
   logic [31:0] compact_pk, compact_cl;

   always_comb begin
      mant_top = nq_ff[23:0];
      if (mant_top[23:16] != '0) begin
         nbytes = 2'd3;
      end else if (mant_top[15:8] != '0) begin
         nbytes = 2'd2;
      end else if (mant_top[7:0] != '0) begin
         nbytes = 2'd1;
      end else begin
         nbytes = 2'd0;
      end
      mant_sh  = 32'(mant_top) << {2'd3 - nbytes, 3'b000};
      size_raw = 6'(k_ff) + 6'(nbytes);
      if ((mant_sh & SIGN_BIT) != '0) begin
         mant_fix = mant_sh >> 8;
         size_fix = size_raw + 6'd1;
      end else begin
         mant_fix = mant_sh;
         size_fix = size_raw;
      end
      compact_pk = {2'b00, size_fix, mant_fix[23:0]};
      compact_cl = (compact_pk > max_ff) ? max_ff : compact_pk;
   end

   always_comb begin
      rsp_in.result_word3 = res_ff[255:192];
      rsp_in.result_word2 = res_ff[191:128];
      rsp_in.result_word1 = res_ff[127:64];
      rsp_in.result_word0 = res_ff[63:0];
      rsp_in.compact_out  = (mode_ff == MODE_TO_TARGET) ? compact_cl : '0;
      rsp_in.status       = stat_ff;
      if (stat_ff != STATUS_OK) begin
         rsp_in              = '0;
         rsp_in.status       = stat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= DEFAULT_MAX_COMPACT;
      end else if (csr_valid) begin
         max_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_data.mode;
         stat_ff <= stat_in;
         den_ff  <= (req_data.mode == MODE_TO_WORK) ? target_in : work_in;
      end
      if (cmd.prep) begin
         nq_ff  <= ~den_ff;
         rem_ff <= '0;
         if (mode_ff == MODE_TO_WORK) begin
            den_ff <= den_ff + 1'b1;
         end
      end
      if (cmd.step) begin
         rem_ff <= take ? trial[WordWidth-1:0] : {rem_ff[WordWidth-2:0], nq_ff[WordWidth-1]};
         nq_ff  <= {nq_ff[WordWidth-2:0], take};
      end
      if (cmd.post) begin
         res_ff <= (mode_ff == MODE_TO_WORK) ? nq_ff + 1'b1 : nq_ff;
         k_ff   <= '0;
      end
      if (cmd.pack_step) begin
         nq_ff <= nq_ff >> 8;
         k_ff  <= k_ff + 1'b1;
      end
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

### sv/compact_target_work_converter_core.sv
// Converts between a compact difficulty target and 256-bit chain work. Mode 0 expands the
// compact target T and returns ~T/(T+1)+1; mode 1 takes work W and returns ~W/W in full plus
// its compact form clamped to the csr register (reset 0x1d00ffff). Zero work gives status 1,
// an exponent above 34 gives status 2, both with all-zero results. One beat is worked at a
// time, from acceptance to result: a load and a prep step, the bit-serial restoring divider,
// a post step to finish the quotient, the byte-wise normalizer for packing, and the loading
// of the output register, which waits until the output slot is free.
// The csr port is always ready; the next request beat is taken while a result still waits.
module compact_target_work_converter_core
   import ctwc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ctwc_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ctwc_rsp_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data
);

   ctwc_cmd_type cmd;
   ctwc_sts_type sts;

   assign csr_ready = 1'b1;

   ctwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   ctwc_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_OK) |->
         (rsp_data.result_word0 == '0) && (rsp_data.result_word1 == '0) &&
         (rsp_data.result_word2 == '0) && (rsp_data.result_word3 == '0) &&
         (rsp_data.compact_out == '0))
      else $error("error beat with nonzero payload");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result without work in progress");
`endif

endmodule
